// ----- design/lsti_pkg.sv -----
// shared types, constants and table functions of the l-system turtle interpreter
package lsti_pkg;

    localparam int ANGLE_STEPS = 72;
    localparam int TURN_STEPS  = 5;
    localparam int QUARTER     = 18;
    localparam int X_RULE_LEN  = 18;

    localparam int COORD_W     = 24;
    localparam int HEAD_W      = 7;
    localparam int STEP_W      = 23;
    localparam int LEVEL_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int XIDX_W      = 5;
    localparam int TRIG_W      = 17;

    localparam logic [LEVEL_W-1:0]        LEVEL_MAX     = 5'd31;
    localparam logic signed [COORD_W-1:0] START_X_RST   = 24'shFF0000;
    localparam logic signed [COORD_W-1:0] START_Y_RST   = 24'shFF0000;
    localparam logic [HEAD_W-1:0]         START_HEAD_RST = 7'd12;
    localparam logic [STEP_W-1:0]         STEP_RST      = 23'd65536;
    localparam logic [LEVEL_W-1:0]        MAX_LEVEL_RST = 5'd4;

    localparam logic [CHAR_W-1:0] CH_X     = 8'h58;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LBR   = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBR   = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    localparam logic [CHAR_W-1:0] X_RULE [X_RULE_LEN] = '{
        CH_F, CH_MINUS, CH_LBR, CH_LBR, CH_X, CH_RBR, CH_PLUS, CH_X, CH_RBR,
        CH_PLUS, CH_F, CH_LBR, CH_PLUS, CH_F, CH_X, CH_RBR, CH_MINUS, CH_X
    };

    localparam logic [15:0] QUARTER_SIN [QUARTER+1] = '{
        16'd0, 16'd2856, 16'd5690, 16'd8481, 16'd11207, 16'd13848, 16'd16384,
        16'd18795, 16'd21063, 16'd23170, 16'd25102, 16'd26842, 16'd28378,
        16'd29698, 16'd30792, 16'd31652, 16'd32270, 16'd32643, 16'd32767
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X       = 3'd0,
        CFG_START_Y       = 3'd1,
        CFG_START_HEADING = 3'd2,
        CFG_STEP_LENGTH   = 3'd3,
        CFG_MAX_LEVEL     = 3'd4
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_UNKNOWN    = 3'd1,
        STAT_EMPTY_POP  = 3'd2,
        STAT_STACK_FULL = 3'd3,
        STAT_FINISHED   = 3'd4,
        STAT_GEN_DONE   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        SC_X, SC_F, SC_PLUS, SC_MINUS, SC_PUSH, SC_POP, SC_OTHER
    } sym_class_t;

    typedef enum logic [2:0] {
        EK_STATUS, EK_CHAR, EK_XRULE, EK_SEG, EK_F_TAIL
    } emit_kind_t;

    typedef enum logic [2:0] {
        TOP_NONE, TOP_GEN, TOP_PLUS, TOP_MINUS, TOP_PUSH, TOP_POP, TOP_MOVE
    } turtle_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_POP_RD, ST_EMIT_ONE, ST_EMIT_X,
        ST_MUL_X, ST_MUL_Y, ST_SUM, ST_EMIT_F0, ST_EMIT_F1
    } ctrl_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic [HEAD_W-1:0]         start_heading;
        logic [STEP_W-1:0]         step_length;
        logic [LEVEL_W-1:0]        max_level;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [HEAD_W-1:0]         heading;
    } turtle_entry_t;

    typedef struct packed {
        logic              load_in;
        logic              len_en;
        logic              mul_en;
        logic              mul_sel;
        logic              sum_en;
        logic              rd_en;
        logic              emit;
        emit_kind_t        kind;
        turtle_op_t        op;
        status_t           status;
        logic              last;
        logic [XIDX_W-1:0] xidx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       finished;
        logic       gen_cmd;
        sym_class_t sclass;
        logic       stack_empty;
        logic       stack_full;
        logic       out_free;
    } dp_stat_t;

    function automatic sym_class_t classify(input logic [CHAR_W-1:0] s);
        sym_class_t c;
        unique case (s)
            CH_X:     c = SC_X;
            CH_F:     c = SC_F;
            CH_PLUS:  c = SC_PLUS;
            CH_MINUS: c = SC_MINUS;
            CH_LBR:   c = SC_PUSH;
            CH_RBR:   c = SC_POP;
            default:  c = SC_OTHER;
        endcase
        return c;
    endfunction

    // valid for values below twice the angle count
    function automatic logic [HEAD_W-1:0] heading_mod(input logic [HEAD_W-1:0] h);
        return (h >= HEAD_W'(ANGLE_STEPS)) ? h - HEAD_W'(ANGLE_STEPS) : h;
    endfunction

    function automatic logic [CHAR_W-1:0] x_rule_char(input logic [XIDX_W-1:0] i);
        return (i < XIDX_W'(X_RULE_LEN)) ? X_RULE[i] : CH_X;
    endfunction

    // q1.15 sine from the quarter-wave table, k below twice the angle count
    function automatic logic signed [TRIG_W-1:0] sin_q15(input logic [HEAD_W-1:0] k);
        logic [HEAD_W-1:0]        kk;
        logic [4:0]               q;
        logic                     neg;
        logic signed [TRIG_W-1:0] mag;
        kk = heading_mod(k);
        if (kk <= HEAD_W'(QUARTER)) begin
            q   = 5'(kk);
            neg = 1'b0;
        end else if (kk <= HEAD_W'(2 * QUARTER)) begin
            q   = 5'(HEAD_W'(2 * QUARTER) - kk);
            neg = 1'b0;
        end else if (kk <= HEAD_W'(3 * QUARTER)) begin
            q   = 5'(kk - HEAD_W'(2 * QUARTER));
            neg = 1'b1;
        end else begin
            q   = 5'(HEAD_W'(ANGLE_STEPS) - kk);
            neg = 1'b1;
        end
        mag = $signed({1'b0, QUARTER_SIN[q]});
        return neg ? -mag : mag;
    endfunction

endpackage

// ----- design/lsti_ctrl.sv -----
// sequencing state machine of the l-system turtle interpreter
module lsti_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lsti_pkg::dp_stat_t   stat,
    output lsti_pkg::ctrl_cmd_t  cmd
);
    import lsti_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [XIDX_W-1:0] xidx_reg, xidx_next;

    emit_kind_t one_kind;
    status_t    one_status;
    turtle_op_t one_op;

    // single-result item decode
    always_comb begin
        one_kind   = EK_CHAR;
        one_status = STAT_OK;
        one_op     = TOP_NONE;
        if (stat.finished) begin
            one_kind   = EK_STATUS;
            one_status = STAT_FINISHED;
        end else if (stat.gen_cmd) begin
            one_kind   = EK_STATUS;
            one_status = STAT_GEN_DONE;
            one_op     = TOP_GEN;
        end else begin
            unique case (stat.sclass)
                SC_PLUS:  one_op = TOP_PLUS;
                SC_MINUS: one_op = TOP_MINUS;
                SC_PUSH: begin
                    if (stat.stack_full) one_status = STAT_STACK_FULL;
                    else                 one_op     = TOP_PUSH;
                end
                SC_POP: begin
                    if (stat.stack_empty) one_status = STAT_EMPTY_POP;
                    else                  one_op     = TOP_POP;
                end
                default: begin
                    one_kind   = EK_STATUS;
                    one_status = STAT_UNKNOWN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            xidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            xidx_reg  <= xidx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        xidx_next  = xidx_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.kind   = EK_STATUS;
        cmd.op     = TOP_NONE;
        cmd.status = STAT_OK;
        cmd.xidx   = xidx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                cmd.len_en = 1'b1;
                xidx_next  = '0;
                if (stat.finished || stat.gen_cmd) begin
                    state_next = ST_EMIT_ONE;
                end else begin
                    case (stat.sclass)
                        SC_X:    state_next = ST_EMIT_X;
                        SC_F:    state_next = ST_MUL_X;
                        SC_POP:  state_next = stat.stack_empty ? ST_EMIT_ONE : ST_POP_RD;
                        default: state_next = ST_EMIT_ONE;
                    endcase
                end
            end
            ST_POP_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT_ONE;
            end
            ST_EMIT_ONE: begin
                cmd.kind   = one_kind;
                cmd.status = one_status;
                cmd.op     = one_op;
                cmd.last   = 1'b1;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_X: begin
                cmd.kind = EK_XRULE;
                cmd.last = (xidx_reg == XIDX_W'(X_RULE_LEN - 1));
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (cmd.last) state_next = ST_IDLE;
                    else          xidx_next  = xidx_reg + 1'b1;
                end
            end
            ST_MUL_X: begin
                cmd.mul_en = 1'b1;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ST_EMIT_F0;
            end
            ST_EMIT_F0: begin
                cmd.kind = EK_SEG;
                cmd.op   = TOP_MOVE;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_EMIT_F1;
                end
            end
            ST_EMIT_F1: begin
                cmd.kind = EK_F_TAIL;
                cmd.last = 1'b1;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_emit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result loaded while output register still occupied");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new transaction accepted while an item is in progress");

    a_xidx_in_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_X) |-> (xidx_reg < XIDX_W'(X_RULE_LEN)))
        else $error("rewrite index ran past the end of the rule");

endmodule

// ----- design/lsti_dpath.sv -----
// turtle state, stack memory, step multiplier and output register
module lsti_dpath #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lsti_pkg::cfg_t                        cfg,
    input  lsti_pkg::ctrl_cmd_t                   cmd,
    output lsti_pkg::dp_stat_t                    stat,
    input  logic                                  s_cmd,
    input  logic [lsti_pkg::CHAR_W-1:0]           s_symbol,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lsti_pkg::CHAR_W-1:0]           m_rewrite_char,
    output logic                                  m_char_valid,
    output logic                                  m_last,
    output logic                                  m_segment_valid,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_seg_x0,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_seg_y0,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_seg_x1,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_seg_y1,
    output logic [lsti_pkg::STATUS_W-1:0]         m_status
);
    import lsti_pkg::*;

    localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W     = $clog2(STACK_DEPTH);
    localparam int PROD_W     = STEP_W + 1 + TRIG_W;
    localparam int FRAC_SHIFT = 15;
    localparam int DELTA_W    = PROD_W - FRAC_SHIFT;
    localparam int SUM_W      = DELTA_W + 1;
    localparam logic signed [SUM_W-1:0] COORD_HI = SUM_W'(24'sh7FFFFF);
    localparam logic signed [SUM_W-1:0] COORD_LO = SUM_W'(24'sh800000);

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v > COORD_HI)      r = COORD_HI[COORD_W-1:0];
        else if (v < COORD_LO) r = COORD_LO[COORD_W-1:0];
        else                   r = v[COORD_W-1:0];
        return r;
    endfunction

    // latched item
    logic              cmd_in_reg;
    logic [CHAR_W-1:0] sym_reg;

    // turtle
    logic signed [COORD_W-1:0] pos_x_reg, pos_y_reg;
    logic [HEAD_W-1:0]         heading_reg;
    logic [LEVEL_W-1:0]        level_reg;
    logic [CNT_W-1:0]          count_reg;

    // step arithmetic
    logic [STEP_W-1:0]         len_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [COORD_W-1:0] new_x_reg, new_y_reg;
    logic signed [TRIG_W-1:0]  trig;
    logic signed [SUM_W-1:0]   sum_x, sum_y;

    // stack
    turtle_entry_t    stack_mem [STACK_DEPTH];
    turtle_entry_t    rd_data_reg;
    logic [CNT_W-1:0] cnt_dec;
    logic [SIDX_W-1:0] push_addr, pop_addr;
    logic             do_push;

    // output register
    logic                      m_valid_reg;
    logic [CHAR_W-1:0]         char_reg;
    logic                      char_valid_reg, last_reg, seg_valid_reg;
    logic signed [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    status_t                   status_reg;
    logic [CHAR_W-1:0]         emit_char;

    assign stat.finished    = (level_reg > cfg.max_level);
    assign stat.gen_cmd     = cmd_in_reg;
    assign stat.sclass      = classify(sym_reg);
    assign stat.stack_empty = (count_reg == '0);
    assign stat.stack_full  = (count_reg >= CNT_W'(STACK_DEPTH));
    assign stat.out_free    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_in_reg <= s_cmd;
            sym_reg    <= s_symbol;
        end
    end

    // cos on the first pass, sin on the second
    assign trig = cmd.mul_sel ? sin_q15(heading_reg)
                              : sin_q15(heading_reg + HEAD_W'(QUARTER));
    // round half up, then drop the fraction bits of the table scale
    assign prod_rnd = prod_reg + PROD_W'(1 << (FRAC_SHIFT - 1));
    assign delta    = prod_rnd[PROD_W-1:FRAC_SHIFT];
    assign sum_x    = SUM_W'(pos_x_reg) + SUM_W'(dx_reg);
    assign sum_y    = SUM_W'(pos_y_reg) + SUM_W'(delta);

    always_ff @(posedge aclk) begin
        if (cmd.len_en) len_reg <= cfg.step_length >> (level_reg - 1'b1);
        if (cmd.mul_en) begin
            prod_reg <= $signed({1'b0, len_reg}) * trig;
            if (cmd.mul_sel) dx_reg <= delta;
        end
        if (cmd.sum_en) begin
            new_x_reg <= sat_coord(sum_x);
            new_y_reg <= sat_coord(sum_y);
        end
    end

    assign cnt_dec   = count_reg - 1'b1;
    assign push_addr = count_reg[SIDX_W-1:0];
    assign pop_addr  = cnt_dec[SIDX_W-1:0];
    assign do_push   = cmd.emit && (cmd.op == TOP_PUSH);

    always_ff @(posedge aclk) begin
        if (do_push) stack_mem[push_addr] <= '{x: pos_x_reg, y: pos_y_reg, heading: heading_reg};
        if (cmd.rd_en) rd_data_reg <= stack_mem[pop_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= START_X_RST;
            pos_y_reg   <= START_Y_RST;
            heading_reg <= START_HEAD_RST;
            level_reg   <= LEVEL_W'(1);
            count_reg   <= '0;
        end else if (cmd.emit) begin
            case (cmd.op)
                TOP_GEN: begin
                    pos_x_reg   <= cfg.start_x;
                    pos_y_reg   <= cfg.start_y;
                    heading_reg <= heading_mod(cfg.start_heading);
                    count_reg   <= '0;
                    if (level_reg < LEVEL_MAX) level_reg <= level_reg + 1'b1;
                end
                TOP_PLUS: begin
                    heading_reg <= (heading_reg >= HEAD_W'(TURN_STEPS))
                        ? heading_reg - HEAD_W'(TURN_STEPS)
                        : heading_reg + HEAD_W'(ANGLE_STEPS - TURN_STEPS);
                end
                TOP_MINUS: heading_reg <= heading_mod(heading_reg + HEAD_W'(TURN_STEPS));
                TOP_PUSH:  count_reg   <= count_reg + 1'b1;
                TOP_POP: begin
                    pos_x_reg   <= rd_data_reg.x;
                    pos_y_reg   <= rd_data_reg.y;
                    heading_reg <= heading_mod(rd_data_reg.heading);
                    count_reg   <= cnt_dec;
                end
                TOP_MOVE: begin
                    pos_x_reg <= new_x_reg;
                    pos_y_reg <= new_y_reg;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cmd.kind)
            EK_CHAR:             emit_char = sym_reg;
            EK_XRULE:            emit_char = x_rule_char(cmd.xidx);
            EK_SEG, EK_F_TAIL:   emit_char = CH_F;
            default:             emit_char = CH_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            char_reg       <= emit_char;
            char_valid_reg <= (cmd.kind != EK_STATUS);
            last_reg       <= cmd.last;
            seg_valid_reg  <= (cmd.kind == EK_SEG);
            status_reg     <= cmd.status;
            if (cmd.kind == EK_SEG) begin
                x0_reg <= pos_x_reg;
                y0_reg <= pos_y_reg;
                x1_reg <= new_x_reg;
                y1_reg <= new_y_reg;
            end else begin
                x0_reg <= '0;
                y0_reg <= '0;
                x1_reg <= '0;
                y1_reg <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_rewrite_char  = char_reg;
    assign m_char_valid    = char_valid_reg;
    assign m_last          = last_reg;
    assign m_segment_valid = seg_valid_reg;
    assign m_seg_x0        = x0_reg;
    assign m_seg_y0        = y0_reg;
    assign m_seg_x1        = x1_reg;
    assign m_seg_y1        = y1_reg;
    assign m_status        = status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |-> !stat.stack_full)
        else $error("push issued into a full stack");

    a_segment_on_first_f: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_segment_valid) |-> (m_char_valid && !m_last))
        else $error("segment on a result other than the first f");

endmodule

// ----- design/lsystem_turtle_interpreter_core.sv -----
// top level of the l-system turtle interpreter: configuration registers and core wiring
// a new item is accepted only after the last result of the one before is loaded
// x streams one result a cycle while the output register is free; a pop reads
// its stack entry first; f spends two multiplier passes and a sum before its results
// reset (synchronous, aresetn low): registers to defaults, turtle to start, level 1
// the stack is empty after reset with no clearing pass: entries are read only after a push
module lsystem_turtle_interpreter_core #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lsti_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lsti_pkg::CFG_DATA_W-1:0]       cfg_data,
    // symbol input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_cmd,
    input  logic [lsti_pkg::CHAR_W-1:0]           s_symbol,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lsti_pkg::CHAR_W-1:0]           m_rewrite_char,
    output logic                                  m_char_valid,
    output logic                                  m_last,
    output logic                                  m_segment_valid,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_seg_x0,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_seg_y0,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_seg_x1,
    output logic signed [lsti_pkg::COORD_W-1:0]   m_seg_y1,
    output logic [lsti_pkg::STATUS_W-1:0]         m_status
);
    import lsti_pkg::*;

    // configuration register file
    logic signed [COORD_W-1:0] start_x_reg, start_y_reg;
    logic [HEAD_W-1:0]         start_heading_reg;
    logic [STEP_W-1:0]         step_length_reg;
    logic [LEVEL_W-1:0]        max_level_reg;
    cfg_t                      cfg;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // writes never stall; a write to an unlisted index is accepted and dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg       <= START_X_RST;
            start_y_reg       <= START_Y_RST;
            start_heading_reg <= START_HEAD_RST;
            step_length_reg   <= STEP_RST;
            max_level_reg     <= MAX_LEVEL_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_START_X:       start_x_reg       <= cfg_data[COORD_W-1:0];
                CFG_START_Y:       start_y_reg       <= cfg_data[COORD_W-1:0];
                CFG_START_HEADING: start_heading_reg <= cfg_data[HEAD_W-1:0];
                CFG_STEP_LENGTH:   step_length_reg   <= cfg_data[STEP_W-1:0];
                CFG_MAX_LEVEL:     max_level_reg     <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // start values only reach the turtle at end of generation or reset
    assign cfg.start_x       = start_x_reg;
    assign cfg.start_y       = start_y_reg;
    assign cfg.start_heading = start_heading_reg;
    assign cfg.step_length   = step_length_reg;
    assign cfg.max_level     = max_level_reg;

    // sequencer: one transaction at a time, results stepped out one a cycle while the output is free
    lsti_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // turtle, stack memory, multiplier and output register
    lsti_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .s_cmd           (s_cmd),
        .s_symbol        (s_symbol),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rewrite_char  (m_rewrite_char),
        .m_char_valid    (m_char_valid),
        .m_last          (m_last),
        .m_segment_valid (m_segment_valid),
        .m_seg_x0        (m_seg_x0),
        .m_seg_y0        (m_seg_y0),
        .m_seg_x1        (m_seg_x1),
        .m_seg_y1        (m_seg_y1),
        .m_status        (m_status)
    );

endmodule
